@@ rtl/assert_macros.svh @@
// Assertion macros shared by the voice allocator RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PVA_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PVA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/pva_pkg.sv @@
// Types and constants of the polyphonic voice allocator.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package pva_pkg;

    // Voice pool size and age counter width.
    localparam int NUM_VOICES = 16;
    localparam int AGE_BITS   = 16;
    localparam int VOICE_BITS = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    // Fixed field widths of the request and result words.
    localparam int REQ_W    = 2;
    localparam int NOTE_W   = 7;
    localparam int FIN_W    = 4;
    localparam int CHOSEN_W = 4;
    localparam int ACTION_W = 3;
    localparam int MASK_W   = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_NOTE_ON  = 2'd0,
        REQ_NOTE_OFF = 2'd1,
        REQ_TICK     = 2'd2,
        REQ_FINISHED = 2'd3
    } req_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_IDLE     = 3'd1,
        ACT_RETRIG   = 3'd2,
        ACT_STOLEN   = 3'd3,
        ACT_RELEASED = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_COMMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic scan_clear;
        logic scan_step;
        logic commit;
    } pva_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_steal;
        logic scan_last;
    } pva_status_t;

endpackage

`default_nettype wire

@@ rtl/pva_ifs.sv @@
// Handshake interfaces for the request and result channels.
// Depends on pva_pkg for the field widths.
`default_nettype none

interface pva_req_if import pva_pkg::*;;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [NOTE_W-1:0] note_number;
    logic [NOTE_W-1:0] note_velocity;
    logic [FIN_W-1:0]  finished_voice;

    modport source (output valid, req_type, note_number, note_velocity, finished_voice,
                    input ready);
    modport sink   (input valid, req_type, note_number, note_velocity, finished_voice,
                    output ready);
endinterface

interface pva_rsp_if import pva_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CHOSEN_W-1:0] chosen_voice;
    logic [ACTION_W-1:0] action;
    logic [MASK_W-1:0]   released_mask;
    logic [NOTE_W-1:0]   start_note;
    logic [NOTE_W-1:0]   start_velocity;

    modport source (output valid, chosen_voice, action, released_mask, start_note,
                    start_velocity, input ready);
    modport sink   (input valid, chosen_voice, action, released_mask, start_note,
                    start_velocity, output ready);
endinterface

`default_nettype wire

@@ rtl/pva_ctrl.sv @@
// Controller state machine of the voice allocator.
// Depends on pva_pkg and assert_macros.svh; drives the datapath commands.
`default_nettype none
`include "assert_macros.svh"

module pva_ctrl
    import pva_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  pva_status_t st,
    output pva_cmd_t   cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (st.need_steal)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // A result is only written into a register that is free.
    `PVA_ASSERT_IMPL(a_commit_free, clk, rst_n, cmd.commit, !out_valid_reg || out_ready)
    // The age scan only runs for a note-on that has to steal a voice.
    `PVA_ASSERT_IMPL(a_scan_steal, clk, rst_n, state_reg == S_SCAN, st.need_steal)

endmodule

`default_nettype wire

@@ rtl/pva_datapath.sv @@
// Datapath of the voice allocator: voice table, age scan and result word.
// Depends on pva_pkg and assert_macros.svh; steered by pva_ctrl.
`default_nettype none
`include "assert_macros.svh"

module pva_datapath
    import pva_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  pva_cmd_t                 cmd,
    output pva_status_t              st,
    input  wire logic [REQ_W-1:0]    req_type,
    input  wire logic [NOTE_W-1:0]   note_number,
    input  wire logic [NOTE_W-1:0]   note_velocity,
    input  wire logic [FIN_W-1:0]    finished_voice,
    output logic [CHOSEN_W-1:0]      chosen_voice,
    output logic [ACTION_W-1:0]      action,
    output logic [MASK_W-1:0]        released_mask,
    output logic [NOTE_W-1:0]        start_note,
    output logic [NOTE_W-1:0]        start_velocity
);

    // Voice table.
    logic [NUM_VOICES-1:0] active_reg;
    logic [NOTE_W-1:0]     note_reg [NUM_VOICES];
    logic [AGE_BITS-1:0]   age_reg  [NUM_VOICES];

    // Latched request word.
    req_t              rq_type_reg;
    logic [NOTE_W-1:0] rq_note_reg;
    logic [NOTE_W-1:0] rq_vel_reg;
    logic [FIN_W-1:0]  rq_fin_reg;

    // Oldest-voice scan.
    logic [VOICE_BITS-1:0] scan_idx_reg;
    logic [VOICE_BITS-1:0] best_idx_reg;
    logic [AGE_BITS-1:0]   best_age_reg;

    // Result word.
    logic [CHOSEN_W-1:0] chosen_reg;
    act_t                action_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [NOTE_W-1:0]   snote_reg;
    logic [NOTE_W-1:0]   svel_reg;

    logic [NUM_VOICES-1:0] match_vec;
    logic                  any_match;
    logic                  any_idle;
    logic [VOICE_BITS-1:0] match_idx;
    logic [VOICE_BITS-1:0] idle_idx;
    logic [VOICE_BITS-1:0] sel_idx;
    act_t                  on_action;
    logic                  fin_ok;
    logic [VOICE_BITS-1:0] fin_idx;

    // Note match per voice and lowest matching and lowest idle voice.
    always_comb
    begin
        match_idx = '0;
        idle_idx  = '0;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            match_vec[i] = active_reg[i] && (note_reg[i] == rq_note_reg);
        end
        for (int i = NUM_VOICES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_idx = VOICE_BITS'(i);
            end
            if (!active_reg[i])
            begin
                idle_idx = VOICE_BITS'(i);
            end
        end
    end

    assign any_match = |match_vec;
    assign any_idle  = !(&active_reg);

    // Voice picked for a note-on: retrigger, then idle, then the oldest.
    always_comb
    begin
        if (any_match)
        begin
            sel_idx   = match_idx;
            on_action = ACT_RETRIG;
        end
        else if (any_idle)
        begin
            sel_idx   = idle_idx;
            on_action = ACT_IDLE;
        end
        else
        begin
            sel_idx   = best_idx_reg;
            on_action = ACT_STOLEN;
        end
    end

    assign fin_ok  = (32'(rq_fin_reg) < NUM_VOICES);
    assign fin_idx = VOICE_BITS'(rq_fin_reg);

    assign st.need_steal = (rq_type_reg == REQ_NOTE_ON) && !any_match && !any_idle;
    assign st.scan_last  = (scan_idx_reg == VOICE_BITS'(NUM_VOICES - 1));

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            rq_type_reg <= req_t'(req_type);
            rq_note_reg <= note_number;
            rq_vel_reg  <= note_velocity;
            rq_fin_reg  <= finished_voice;
        end
    end

    // Oldest-voice scan, one voice per cycle; ties keep the lower index.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_clear)
        begin
            scan_idx_reg <= '0;
            best_idx_reg <= '0;
            best_age_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (age_reg[scan_idx_reg] > best_age_reg)
            begin
                best_age_reg <= age_reg[scan_idx_reg];
                best_idx_reg <= scan_idx_reg;
            end
            if (!st.scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    // Voice table update when the result is committed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                note_reg[i] <= '0;
                age_reg[i]  <= '0;
            end
        end
        else if (cmd.commit)
        begin
            unique case (rq_type_reg)
                REQ_NOTE_ON:
                begin
                    active_reg[sel_idx] <= 1'b1;
                    note_reg[sel_idx]   <= rq_note_reg;
                    age_reg[sel_idx]    <= '0;
                end
                REQ_TICK:
                begin
                    for (int i = 0; i < NUM_VOICES; i++)
                    begin
                        if (active_reg[i] && (age_reg[i] != '1))
                        begin
                            age_reg[i] <= age_reg[i] + 1'b1;
                        end
                    end
                end
                REQ_FINISHED:
                begin
                    if (fin_ok)
                    begin
                        active_reg[fin_idx] <= 1'b0;
                    end
                end
                default:
                begin
                    // Note-off leaves the table as it is.
                end
            endcase
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            chosen_reg <= '0;
            action_reg <= ACT_NONE;
            mask_reg   <= '0;
            snote_reg  <= '0;
            svel_reg   <= '0;
            unique case (rq_type_reg)
                REQ_NOTE_ON:
                begin
                    chosen_reg <= CHOSEN_W'(sel_idx);
                    action_reg <= on_action;
                    snote_reg  <= rq_note_reg;
                    svel_reg   <= rq_vel_reg;
                end
                REQ_NOTE_OFF:
                begin
                    mask_reg   <= MASK_W'(match_vec);
                    action_reg <= any_match ? ACT_RELEASED : ACT_NONE;
                end
                default:
                begin
                    // Tick and voice-finished give an all-zero word.
                end
            endcase
        end
    end

    assign chosen_voice   = chosen_reg;
    assign action         = action_reg;
    assign released_mask  = mask_reg;
    assign start_note     = snote_reg;
    assign start_velocity = svel_reg;

    // A started voice is active right after the commit.
    `PVA_ASSERT_NEXT(a_start_active, clk, rst_n,
        cmd.commit && (rq_type_reg == REQ_NOTE_ON), active_reg[$past(sel_idx)])
    // The running maximum of the scan never falls.
    `PVA_ASSERT_NEXT(a_scan_mono, clk, rst_n, cmd.scan_step,
        best_age_reg >= $past(best_age_reg))

endmodule

`default_nettype wire

@@ rtl/polyphonic_voice_allocator_top.sv @@
// Top level of the polyphonic voice allocator.
// Depends on pva_pkg, pva_ifs, pva_ctrl and pva_datapath.
//
// Usage:
//   req carries one event word: note on, note off, age tick or voice finished.
//   rsp returns exactly one result word per event, in order.
//   A word moves when valid and ready are both high at a rising clock edge.
//   The block works on one event at a time. req.ready is high only while the
//   controller is idle; an accepted event is evaluated in the next cycle, and
//   its result is written to the output register, which raises rsp.valid,
//   once that register is free. A note-on that finds no matching and no idle
//   voice scans all voice ages, one voice per cycle, before that write.
//   The result register decouples the two sides: the next event is accepted
//   and evaluated while an earlier result waits; only the commit of the next
//   result waits for rsp.ready.
//   Reset (rst_n low, asynchronous) marks every voice idle with note and age
//   zero and empties the result register.
`default_nettype none

module polyphonic_voice_allocator_top
    import pva_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pva_req_if.sink   req,
    pva_rsp_if.source rsp
);

    pva_cmd_t    cmd;
    pva_status_t st;

    pva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    pva_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .req_type       (req.req_type),
        .note_number    (req.note_number),
        .note_velocity  (req.note_velocity),
        .finished_voice (req.finished_voice),
        .chosen_voice   (rsp.chosen_voice),
        .action         (rsp.action),
        .released_mask  (rsp.released_mask),
        .start_note     (rsp.start_note),
        .start_velocity (rsp.start_velocity)
    );

endmodule

`default_nettype wire
